@@ design/hbp_pkg.sv @@
// ----------------------------------------------------------------------------
// hbp_pkg: shared types and constants for heading_between_points
// Fixed-point widths, the CORDIC arctangent table, fold codes and the job
// record that travels from the front end to the CORDIC back end.
// ----------------------------------------------------------------------------
package hbp_pkg;

	// Defaults for the top-level parameters
	localparam int unsigned DEF_COORD_WIDTH  = 24;
	localparam int unsigned DEF_CORDIC_STEPS = 16;

	// Normalizer: the larger of dx, dy ends with its top bit here
	localparam int unsigned NORM_TOP_BIT = 40;
	localparam int unsigned NORM_W       = NORM_TOP_BIT + 1;
	localparam int unsigned NORM_STAGES  = 6;

	// CORDIC datapath: x and y carry gain headroom, z counts 2^-20 degree
	localparam int unsigned CORDIC_W       = NORM_W + 3;
	localparam int unsigned ANGLE_W        = 29;
	localparam int unsigned ATAN_TABLE_LEN = 24;

	// Decoupling queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// Fold and scale
	localparam int unsigned FOLD_W = 29;
	localparam logic signed [ANGLE_W-1:0] ANGLE_90 = 29'sd94371840;
	localparam logic [FOLD_W-1:0] DEG_180 = 29'd188743680;
	localparam logic [FOLD_W-1:0] DEG_360 = 29'd377487360;

	localparam int unsigned SCALE_MUL_W = 12;
	localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = 12'd2728;
	localparam int unsigned PROD_W      = FOLD_W + SCALE_MUL_W;
	localparam logic [PROD_W-1:0] ROUND_ADD = 41'd7864320;
	localparam int unsigned SCALE_SHIFT = 20;
	localparam int unsigned QUOT_W      = PROD_W - SCALE_SHIFT;

	// Divide by 15 as multiply by ceil(2^25 / 15), exact over the quotient range
	localparam int unsigned RECIP_W     = 22;
	localparam logic [RECIP_W-1:0] RECIP_MUL = 22'd2236963;
	localparam int unsigned RECIP_SHIFT = 25;
	localparam int unsigned RPROD_W     = QUOT_W + RECIP_W;
	localparam int unsigned HQ_W        = RPROD_W - RECIP_SHIFT;

	localparam int unsigned HEADING_W = 16;
	localparam logic [HEADING_W-1:0] HEADING_MAX = 16'd65472;

	// atan(2^-i) in units of 2^-20 degree, rounded to nearest
	localparam logic signed [ANGLE_W-1:0] ATAN_DEG [0:ATAN_TABLE_LEN-1] = '{
		29'sd47185920, 29'sd27855475, 29'sd14718068, 29'sd7471121,
		29'sd3750058,  29'sd1876857,  29'sd938658,   29'sd469357,
		29'sd234682,   29'sd117342,   29'sd58671,    29'sd29335,
		29'sd14668,    29'sd7334,     29'sd3667,     29'sd1833,
		29'sd917,      29'sd458,      29'sd229,      29'sd115,
		29'sd57,       29'sd29,       29'sd14,       29'sd7
	};

	// Quadrant fold applied to the first-quadrant angle
	typedef enum logic [1:0] {
		FOLD_SUB180,
		FOLD_ADD180,
		FOLD_PLAIN,
		FOLD_SUB360
	} fold_t;

	typedef struct packed {
		fold_t fold;
		logic  dx_zero;
	} hbp_tag_t;

	// One normalized job: x holds dy, y holds dx, both shifted alike
	typedef struct packed {
		hbp_tag_t          tag;
		logic [NORM_W-1:0] x;
		logic [NORM_W-1:0] y;
	} hbp_job_t;

endpackage

@@ design/hbp_point_if.sv @@
// ----------------------------------------------------------------------------
// hbp_point_if: point-pair channel
// Valid/ready channel carrying two signed Q16.8 points per beat.
// ----------------------------------------------------------------------------
interface hbp_point_if
	import hbp_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = DEF_COORD_WIDTH
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] first_x;
	logic signed [COORD_WIDTH-1:0] first_y;
	logic signed [COORD_WIDTH-1:0] second_x;
	logic signed [COORD_WIDTH-1:0] second_y;

	modport source (output valid, first_x, first_y, second_x, second_y, input ready);
	modport sink (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

@@ design/hbp_heading_if.sv @@
// ----------------------------------------------------------------------------
// hbp_heading_if: heading channel
// Valid/ready channel carrying one unsigned Q16.0 heading per beat, LSB 15/2728 degree.
// ----------------------------------------------------------------------------
interface hbp_heading_if
	import hbp_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [HEADING_W-1:0] heading_out;

	modport source (output valid, heading_out, input ready);
	modport sink (input valid, heading_out, output ready);
endinterface

@@ design/hbp_front.sv @@
// ----------------------------------------------------------------------------
// hbp_front: point intake and normalization
// Forms |dx| and |dy|, picks the quadrant fold, then left-justifies both
// magnitudes through a pipelined logarithmic normalizer.
// ----------------------------------------------------------------------------
module hbp_front
	import hbp_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = DEF_COORD_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	hbp_point_if.sink    points,
	output logic         job_valid,
	input  logic         job_ready,
	output hbp_job_t     job
);

	localparam int unsigned DIFF_W = COORD_WIDTH + 1;

	logic signed [DIFF_W-1:0] dx_fwd, dx_rev, dy_fwd, dy_rev;
	logic [DIFF_W-1:0]        dx_abs, dy_abs;
	hbp_tag_t                 tag_in;

	logic [NORM_STAGES:0]    vld_sn;
	logic [NORM_W-1:0]       nx_sn  [0:NORM_STAGES];
	logic [NORM_W-1:0]       ny_sn  [0:NORM_STAGES];
	hbp_tag_t                tag_sn [0:NORM_STAGES];
	logic [NORM_W-1:0]       nx_nxt [0:NORM_STAGES-1];
	logic [NORM_W-1:0]       ny_nxt [0:NORM_STAGES-1];
	logic                    adv;

	// Stall the whole front only when the last stage holds a beat the queue refuses
	assign adv          = job_ready | ~vld_sn[NORM_STAGES];
	assign points.ready = adv;

	// Form both signed differences and their negations, pick the magnitudes and the fold
	always_comb begin
		dx_fwd = DIFF_W'(points.first_x) - DIFF_W'(points.second_x);
		dx_rev = DIFF_W'(points.second_x) - DIFF_W'(points.first_x);
		dy_fwd = DIFF_W'(points.first_y) - DIFF_W'(points.second_y);
		dy_rev = DIFF_W'(points.second_y) - DIFF_W'(points.first_y);
		dx_abs = dx_fwd[DIFF_W-1] ? dx_rev : dx_fwd;
		dy_abs = dy_fwd[DIFF_W-1] ? dy_rev : dy_fwd;
		if (dy_abs == '0) begin
			dy_abs = DIFF_W'(1);
		end
		tag_in.dx_zero = (dx_fwd == '0);
		if (!dy_fwd[DIFF_W-1]) begin
			tag_in.fold = dx_fwd[DIFF_W-1] ? FOLD_SUB180 : FOLD_ADD180;
			if (!dx_rev[DIFF_W-1]) begin
				tag_in.fold = FOLD_SUB180;
			end
		end else begin
			tag_in.fold = dx_fwd[DIFF_W-1] ? FOLD_PLAIN : FOLD_SUB360;
		end
	end

	// Shift both by 32, 16, .. 1 where the top bits of their OR are clear
	always_comb begin
		for (int k = 0; k < NORM_STAGES; k++) begin
			if (((nx_sn[k] | ny_sn[k]) >> (NORM_W - (1 << (NORM_STAGES - 1 - k)))) == '0) begin
				nx_nxt[k] = nx_sn[k] << (1 << (NORM_STAGES - 1 - k));
				ny_nxt[k] = ny_sn[k] << (1 << (NORM_STAGES - 1 - k));
			end else begin
				nx_nxt[k] = nx_sn[k];
				ny_nxt[k] = ny_sn[k];
			end
		end
	end

	// Advance the valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= '0;
		end else if (adv) begin
			vld_sn <= {vld_sn[NORM_STAGES-1:0], points.valid};
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (adv) begin
			nx_sn[0]  <= NORM_W'(dy_abs);
			ny_sn[0]  <= NORM_W'(dx_abs);
			tag_sn[0] <= tag_in;
			for (int k = 0; k < NORM_STAGES; k++) begin
				nx_sn[k+1]  <= nx_nxt[k];
				ny_sn[k+1]  <= ny_nxt[k];
				tag_sn[k+1] <= tag_sn[k];
			end
		end
	end

	assign job_valid = vld_sn[NORM_STAGES];
	assign job.tag   = tag_sn[NORM_STAGES];
	assign job.x     = nx_sn[NORM_STAGES];
	assign job.y     = ny_sn[NORM_STAGES];

endmodule

@@ design/hbp_queue.sv @@
// ----------------------------------------------------------------------------
// hbp_queue: job queue
// Small register FIFO that lets the front end and the CORDIC back end stall
// independently of each other.
// ----------------------------------------------------------------------------
module hbp_queue
	import hbp_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  hbp_job_t push_job,
	output logic     pop_valid,
	input  logic     pop_ready,
	output hbp_job_t pop_job
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	hbp_job_t          slot_q [0:DEPTH-1];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;
	assign pop_job    = slot_q[rd_ptr_q];

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

@@ design/hbp_back.sv @@
// ----------------------------------------------------------------------------
// hbp_back: CORDIC angle, fold and scale
// One vectoring CORDIC step per stage, then clamp and quadrant fold, then the
// scale to heading units as two registered multiplies, then the output beat.
// ----------------------------------------------------------------------------
module hbp_back
	import hbp_pkg::*;
#(
	parameter int unsigned CORDIC_STEPS = DEF_CORDIC_STEPS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  hbp_job_t      job,
	hbp_heading_if.source heading
);

	localparam int unsigned N = CORDIC_STEPS;

	logic                       adv;
	logic [N-1:0]               vc_sn;
	logic signed [CORDIC_W-1:0] cx_sn  [0:N-1];
	logic signed [CORDIC_W-1:0] cy_sn  [0:N-1];
	logic signed [ANGLE_W-1:0]  cz_sn  [0:N-1];
	hbp_tag_t                   ctag_sn [0:N-1];
	logic signed [CORDIC_W-1:0] cx_in  [0:N-1];
	logic signed [CORDIC_W-1:0] cy_in  [0:N-1];
	logic signed [ANGLE_W-1:0]  cz_in  [0:N-1];
	logic signed [CORDIC_W-1:0] cx_nxt [0:N-1];
	logic signed [CORDIC_W-1:0] cy_nxt [0:N-1];
	logic signed [ANGLE_W-1:0]  cz_nxt [0:N-1];
	logic signed [CORDIC_W-1:0] xs, ys;

	logic                  vf_s, vm_s, vr_s, vo_q;
	logic signed [ANGLE_W-1:0] z_last, angle;
	logic [FOLD_W-1:0]     folded, folded_sf;
	logic [PROD_W-1:0]     prod_sm, rounded;
	logic [RPROD_W-1:0]    rprod_sr;
	logic [HQ_W-1:0]       hq;
	logic [HEADING_W-1:0]  heading_q;

	// Stall the back end only when the output beat is held
	assign adv       = heading.ready | ~vo_q;
	assign job_ready = adv;

	// Feed each step from the queue head or the previous stage
	always_comb begin
		cx_in[0] = CORDIC_W'(job.x);
		cy_in[0] = CORDIC_W'(job.y);
		cz_in[0] = '0;
		for (int k = 1; k < N; k++) begin
			cx_in[k] = cx_sn[k-1];
			cy_in[k] = cy_sn[k-1];
			cz_in[k] = cz_sn[k-1];
		end
	end

	// Rotate toward y = 0, shifts round toward minus infinity
	always_comb begin
		xs = '0;
		ys = '0;
		for (int k = 0; k < N; k++) begin
			xs = cx_in[k] >>> k;
			ys = cy_in[k] >>> k;
			if (!cy_in[k][CORDIC_W-1]) begin
				cx_nxt[k] = cx_in[k] + ys;
				cy_nxt[k] = cy_in[k] - xs;
				cz_nxt[k] = cz_in[k] + ATAN_DEG[k];
			end else begin
				cx_nxt[k] = cx_in[k] - ys;
				cy_nxt[k] = cy_in[k] + xs;
				cz_nxt[k] = cz_in[k] - ATAN_DEG[k];
			end
		end
	end

	// Clamp to 0..90 degrees, bypass when dx is zero, then fold by quadrant
	always_comb begin
		z_last = cz_sn[N-1];
		if (ctag_sn[N-1].dx_zero || z_last[ANGLE_W-1]) begin
			angle = '0;
		end else if (z_last > ANGLE_90) begin
			angle = ANGLE_90;
		end else begin
			angle = z_last;
		end
		case (ctag_sn[N-1].fold)
			FOLD_SUB180: folded = DEG_180 - FOLD_W'(angle);
			FOLD_ADD180: folded = DEG_180 + FOLD_W'(angle);
			FOLD_PLAIN:  folded = FOLD_W'(angle);
			FOLD_SUB360: folded = DEG_360 - FOLD_W'(angle);
			default:     folded = FOLD_W'(angle);
		endcase
	end

	// Round, drop 2^20, then divide by 15 through the reciprocal
	assign rounded = prod_sm + ROUND_ADD;
	assign hq      = rprod_sr[RPROD_W-1:RECIP_SHIFT];

	// Advance the valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_sn <= '0;
			vf_s  <= 1'b0;
			vm_s  <= 1'b0;
			vr_s  <= 1'b0;
			vo_q  <= 1'b0;
		end else if (adv) begin
			vc_sn <= {vc_sn[N-2:0], job_valid};
			vf_s  <= vc_sn[N-1];
			vm_s  <= vf_s;
			vr_s  <= vm_s;
			vo_q  <= vr_s;
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (adv) begin
			ctag_sn[0] <= job.tag;
			for (int k = 0; k < N; k++) begin
				cx_sn[k] <= cx_nxt[k];
				cy_sn[k] <= cy_nxt[k];
				cz_sn[k] <= cz_nxt[k];
			end
			for (int k = 1; k < N; k++) begin
				ctag_sn[k] <= ctag_sn[k-1];
			end
			folded_sf <= folded;
			prod_sm   <= PROD_W'(folded_sf) * PROD_W'(SCALE_MUL);
			rprod_sr  <= RPROD_W'(rounded[PROD_W-1:SCALE_SHIFT]) * RPROD_W'(RECIP_MUL);
			heading_q <= (hq > HQ_W'(HEADING_MAX)) ? HEADING_MAX : hq[HEADING_W-1:0];
		end
	end

	assign heading.valid       = vo_q;
	assign heading.heading_out = heading_q;

endmodule

@@ design/heading_between_points.sv @@
// ----------------------------------------------------------------------------
// heading_between_points: compass heading between two points
// Accepts one point pair per beat and returns a Q16.0 heading (LSB 15/2728 degree) per pair.
// ----------------------------------------------------------------------------
// Each accepted beat of two signed Q16.8 points yields exactly one heading
// beat, in order. A new pair is taken every cycle while the output is taken.
// From accept to result valid a beat passes the difference register, the
// normalizer stages, the job queue, the CORDIC stages, and the registers for
// clamp/fold, the scale multiply, the divide-by-15 multiply and the output.
// Equal points give heading 32736 (180 degrees). The block holds no state
// besides the in-flight beats.
// ----------------------------------------------------------------------------
module heading_between_points
	import hbp_pkg::*;
#(
	parameter int unsigned COORD_WIDTH  = DEF_COORD_WIDTH,
	parameter int unsigned CORDIC_STEPS = DEF_CORDIC_STEPS
) (
	input  logic          clk,
	input  logic          arst_n,
	hbp_point_if.sink     points,
	hbp_heading_if.source heading
);

	logic     fq_valid, fq_ready, qb_valid, qb_ready;
	hbp_job_t fq_job, qb_job;

	// Difference, fold choice and normalization
	hbp_front #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.points    (points),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job)
	);

	// Decouple front and back
	hbp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_job   (fq_job),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_job    (qb_job)
	);

	// CORDIC, fold and scale
	hbp_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job       (qb_job),
		.heading   (heading)
	);

endmodule
